// ===== src/ipv4_longest_prefix_router_unit_macros.svh =====
// Assertion macros for the longest-prefix router checker
`ifndef IPV4_LONGEST_PREFIX_ROUTER_UNIT_MACROS_SVH
`define IPV4_LONGEST_PREFIX_ROUTER_UNIT_MACROS_SVH

// same-cycle implication
`define IPLPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("router check failed");

// next-cycle implication
`define IPLPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("router check failed");

`endif

// ===== src/iplpr_pkg.sv =====
// Shared types, codes and helpers for the longest-prefix router
package iplpr_pkg;

    localparam int ADDR_W         = 32;
    localparam int LEN_W          = 6;
    localparam int PORT_W         = 4;
    localparam int TTL_W          = 8;
    localparam int STATUS_W       = 3;
    localparam int MAX_ROUTES_DEF = 32;
    localparam int PORT_COUNT     = 16;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_FWD = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ADDED       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FORWARDED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ROUTE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TTL_EXPIRED = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
        logic              hop_vld;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
    } route_t;

    localparam int ROUTE_W = $bits(route_t);

    // lengths of 32 and above compare every bit, zero compares none
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len >= LEN_W'(ADDR_W))
            m = '1;
        else
            m = ~({ADDR_W{1'b1}} >> len);
        return m;
    endfunction

endpackage

// ===== src/iplpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module iplpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ipv4_longest_prefix_router_unit.sv =====
// Longest-prefix routing table: route adds and datagram forwarding lookups
// Add: result strobed at the accepting edge; busy stays low.
// Forward: one stored route compared per cycle through the table RAM read port;
//   busy stays high until the result is strobed on done.
// The receiver cannot stall; each result word is shown for one cycle on done.
// Reset (rst_n, async, active low) empties the table and clears the default route.
module ipv4_longest_prefix_router_unit
    import iplpr_pkg::*;
#(
    parameter int MAX_ROUTES = MAX_ROUTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                opcode,
    input  logic [ADDR_W-1:0]   addr,
    input  logic [LEN_W-1:0]    prefix_len,
    input  logic                hop_present,
    input  logic [ADDR_W-1:0]   hop_addr,
    input  logic [PORT_W-1:0]   port_num,
    input  logic [TTL_W-1:0]    ttl_in,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [PORT_W-1:0]   out_port,
    output logic [ADDR_W-1:0]   out_hop,
    output logic [TTL_W-1:0]    ttl_out
);

    localparam int AW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int CW = $clog2(MAX_ROUTES + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic              found_reg, found_next;
    logic [LEN_W-1:0]  best_len_reg, best_len_next;
    logic              best_hop_vld_reg, best_hop_vld_next;
    logic [ADDR_W-1:0] best_hop_reg, best_hop_next;
    logic [PORT_W-1:0] best_port_reg, best_port_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic [TTL_W-1:0]  ttl_reg, ttl_next;
    logic              def_vld_reg, def_vld_next;
    logic              def_hop_vld_reg, def_hop_vld_next;
    logic [ADDR_W-1:0] def_hop_reg, def_hop_next;
    logic [PORT_W-1:0] def_port_reg, def_port_next;
    logic              done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [PORT_W-1:0] out_port_reg, out_port_next;
    logic [ADDR_W-1:0] out_hop_reg, out_hop_next;
    logic [TTL_W-1:0]  ttl_out_reg, ttl_out_next;

    logic              accept;
    logic              table_full;
    logic              ram_we;
    route_t            wr_route;
    route_t            rd_route;
    logic [ROUTE_W-1:0] rd_data;
    logic [ADDR_W-1:0] cmp_mask;
    logic              hit;
    logic              sel_vld;
    logic              sel_hop_vld;
    logic [ADDR_W-1:0] sel_hop;
    logic [PORT_W-1:0] sel_port;

    assign accept     = start && (state_reg == S_IDLE);
    assign table_full = (count_reg >= CW'(MAX_ROUTES));
    assign ram_we     = accept && (opcode == OP_ADD) && !table_full;

    assign wr_route.prefix  = addr;
    assign wr_route.length  = prefix_len;
    assign wr_route.hop_vld = hop_present;
    assign wr_route.hop     = hop_addr;
    assign wr_route.port    = port_num;

    iplpr_ram #(
        .WIDTH (ROUTE_W),
        .DEPTH (MAX_ROUTES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_route),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    assign rd_route = route_t'(rd_data);

    // strict length compare keeps the earliest entry on ties and skips zero lengths
    assign cmp_mask = len_mask(rd_route.length);
    assign hit = pend_reg && (((dst_reg ^ rd_route.prefix) & cmp_mask) == '0)
                 && (rd_route.length > best_len_reg);

    assign sel_vld     = found_reg || def_vld_reg;
    assign sel_hop_vld = found_reg ? best_hop_vld_reg : def_hop_vld_reg;
    assign sel_hop     = found_reg ? best_hop_reg : def_hop_reg;
    assign sel_port    = found_reg ? best_port_reg : def_port_reg;

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        pend_next         = pend_reg;
        found_next        = found_reg;
        best_len_next     = best_len_reg;
        best_hop_vld_next = best_hop_vld_reg;
        best_hop_next     = best_hop_reg;
        best_port_next    = best_port_reg;
        dst_next          = dst_reg;
        ttl_next          = ttl_reg;
        def_vld_next      = def_vld_reg;
        def_hop_vld_next  = def_hop_vld_reg;
        def_hop_next      = def_hop_reg;
        def_port_next     = def_port_reg;
        done_next         = 1'b0;
        status_next       = status_reg;
        out_port_next     = out_port_reg;
        out_hop_next      = out_hop_reg;
        ttl_out_next      = ttl_out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_ADD)
                    begin
                        if (addr == '0 && prefix_len == '0)
                        begin
                            def_vld_next     = 1'b1;
                            def_hop_vld_next = hop_present;
                            def_hop_next     = hop_addr;
                            def_port_next    = port_num;
                        end
                        if (!table_full)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        done_next     = 1'b1;
                        status_next   = table_full ? ST_FULL : ST_ADDED;
                        out_port_next = '0;
                        out_hop_next  = '0;
                        ttl_out_next  = '0;
                    end
                    else
                    begin
                        dst_next      = addr;
                        ttl_next      = ttl_in;
                        idx_next      = '0;
                        pend_next     = 1'b0;
                        found_next    = 1'b0;
                        best_len_next = '0;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    found_next        = 1'b1;
                    best_len_next     = rd_route.length;
                    best_hop_vld_next = rd_route.hop_vld;
                    best_hop_next     = rd_route.hop;
                    best_port_next    = rd_route.port;
                end
                if (idx_reg != count_reg)
                begin
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // all reads issued and the last compare already folded in
                if (idx_reg == count_reg && !pend_reg)
                begin
                    done_next     = 1'b1;
                    out_port_next = '0;
                    out_hop_next  = '0;
                    ttl_out_next  = '0;
                    if (!sel_vld || 32'(sel_port) >= PORT_COUNT)
                    begin
                        status_next = ST_NO_ROUTE;
                    end
                    else if (ttl_reg <= TTL_W'(1))
                    begin
                        status_next = ST_TTL_EXPIRED;
                    end
                    else
                    begin
                        status_next   = ST_FORWARDED;
                        out_port_next = sel_port;
                        out_hop_next  = sel_hop_vld ? sel_hop : dst_reg;
                        ttl_out_next  = ttl_reg - TTL_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            idx_reg         <= '0;
            pend_reg        <= 1'b0;
            found_reg       <= 1'b0;
            best_len_reg    <= '0;
            def_vld_reg     <= 1'b0;
            def_hop_vld_reg <= 1'b0;
            def_hop_reg     <= '0;
            def_port_reg    <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            idx_reg         <= idx_next;
            pend_reg        <= pend_next;
            found_reg       <= found_next;
            best_len_reg    <= best_len_next;
            def_vld_reg     <= def_vld_next;
            def_hop_vld_reg <= def_hop_vld_next;
            def_hop_reg     <= def_hop_next;
            def_port_reg    <= def_port_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_hop_vld_reg <= best_hop_vld_next;
        best_hop_reg     <= best_hop_next;
        best_port_reg    <= best_port_next;
        dst_reg          <= dst_next;
        ttl_reg          <= ttl_next;
        status_reg       <= status_next;
        out_port_reg     <= out_port_next;
        out_hop_reg      <= out_hop_next;
        ttl_out_reg      <= ttl_out_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign out_port = out_port_reg;
    assign out_hop  = out_hop_reg;
    assign ttl_out  = ttl_out_reg;

endmodule

// ===== src/iplpr_checker.sv =====
// Port-level checks for the longest-prefix router, bound to the top level
`include "ipv4_longest_prefix_router_unit_macros.svh"

module iplpr_checker
    import iplpr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [STATUS_W-1:0] status,
    input logic [PORT_W-1:0]   out_port,
    input logic [ADDR_W-1:0]   out_hop,
    input logic [TTL_W-1:0]    ttl_out
);

    // an accepted word either answers at once or starts a lookup
    `IPLPR_ASSERT_NXT(a_accept_moves, clk, rst_n, start && !busy, busy || done)

    // a lookup ends only by delivering its result
    `IPLPR_ASSERT_NOW(a_lookup_ends_done, clk, rst_n, $fell(busy), done)

    // anything but a forward carries zero payload
    `IPLPR_ASSERT_NOW(a_drop_zero, clk, rst_n, done && status != ST_FORWARDED,
        out_port == '0 && out_hop == '0 && ttl_out == '0)

    // a forwarded datagram never leaves with zero ttl
    `IPLPR_ASSERT_NOW(a_fwd_ttl, clk, rst_n, done && status == ST_FORWARDED,
        ttl_out != '0)

endmodule

bind ipv4_longest_prefix_router_unit iplpr_checker u_iplpr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .status   (status),
    .out_port (out_port),
    .out_hop  (out_hop),
    .ttl_out  (ttl_out)
);
